// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file sdi_checker.sv.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define SDI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sdi check failed");

// Condition must never be seen out of reset.
`define SDI_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sdi forbidden condition seen");

`endif

// ===== src/sdi_pkg.sv =====
// Package for the SD card SPI init sequencer: phase and status codes,
// command constants and the state, config and result structs. No dependencies.
package sdi_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DUMMY_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_POLLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACMD41_RETRIES = 2'd2;

	localparam logic [4:0] DUMMY_RST = 5'd10;
	localparam logic [3:0] POLLS_RST = 4'd8;
	localparam logic [9:0] RETRIES_RST = 10'd200;
	localparam logic [9:0] RETRY_SAT = 10'h3ff;

	// phase codes
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_DUMMY = 3'd1;
	localparam logic [2:0] PH_CMD0 = 3'd2;
	localparam logic [2:0] PH_CMD8 = 3'd3;
	localparam logic [2:0] PH_CMD55 = 3'd4;
	localparam logic [2:0] PH_ACMD41 = 3'd5;
	localparam logic [2:0] PH_CMD58 = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_CMD0_BAD = 3'd1;
	localparam logic [2:0] ST_CMD8_BAD = 3'd2;
	localparam logic [2:0] ST_ECHO_BAD = 3'd3;
	localparam logic [2:0] ST_CMD55_BAD = 3'd4;
	localparam logic [2:0] ST_ACMD41_BAD = 3'd5;
	localparam logic [2:0] ST_RETRY_OUT = 3'd6;

	// command frame constants
	localparam logic [5:0] IDX_CMD0 = 6'd0;
	localparam logic [5:0] IDX_CMD8 = 6'd8;
	localparam logic [5:0] IDX_CMD55 = 6'd55;
	localparam logic [5:0] IDX_ACMD41 = 6'd41;
	localparam logic [5:0] IDX_CMD58 = 6'd58;
	localparam logic [7:0] CMD_START = 8'h40;
	localparam logic [7:0] CRC_CMD0 = 8'h95;
	localparam logic [7:0] CRC_CMD8 = 8'h87;
	localparam logic [7:0] CRC_END = 8'h01;
	localparam logic [31:0] ARG_CMD8 = 32'h0000_01aa;
	localparam logic [31:0] ARG_HCS = 32'h4000_0000;
	localparam logic [15:0] ECHO_PATTERN = 16'h01aa;
	localparam logic [7:0] FILL_BYTE = 8'hff;
	localparam logic [7:0] R1_IDLE = 8'h01;
	localparam logic [7:0] R1_READY = 8'h00;

	typedef struct packed {
		logic [4:0] dummy_bytes;
		logic [3:0] response_polls;
		logic [9:0] acmd41_retries;
	} sdi_cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [4:0]  byte_count;
		logic [3:0]  poll_count;
		logic [9:0]  retry_count;
		logic        is_version_two;
		logic [7:0]  response_code;
		logic        response_timed_out;
		logic [31:0] trailer_word;
		logic [2:0]  final_status;
	} sdi_state_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       select_low;
		logic       select_pulse;
		logic       done_res;
		logic [2:0] status;
		logic       card_v2;
		logic       high_capacity;
	} sdi_result_t;

endpackage

// ===== src/sdi_if.sv =====
// Handshake channel interfaces for the SD card SPI init sequencer.
// Depends on nothing; widths follow the sequencer's item, result and config words.
interface sdi_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rx_byte;
	modport source(output valid, kind, rx_byte, input ready);
	modport sink(input valid, kind, rx_byte, output ready);
endinterface

interface sdi_result_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       select_low;
	logic       select_pulse;
	logic       done_res;
	logic [2:0] status;
	logic       card_v2;
	logic       high_capacity;
	modport source(output valid, tx_valid, tx_byte, select_low, select_pulse, done_res,
		status, card_v2, high_capacity, input ready);
	modport sink(input valid, tx_valid, tx_byte, select_low, select_pulse, done_res,
		status, card_v2, high_capacity, output ready);
endinterface

interface sdi_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr;
	logic [9:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

// ===== src/sdi_step.sv =====
// Next-state and result logic for one received word of the init sequence.
// Depends on sdi_pkg; purely combinational, registered by the top level.
module sdi_step (
	input  sdi_pkg::sdi_state_t  st,
	input  sdi_pkg::sdi_cfg_t    cfg,
	input  logic                 kind,
	input  logic [7:0]           rx_byte,
	output sdi_pkg::sdi_state_t  nx,
	output sdi_pkg::sdi_result_t res
);
	import sdi_pkg::*;

	function automatic logic [7:0] frame_byte(input logic [2:0] ph, input logic [2:0] k,
		input logic v2);
		logic [5:0]  idx;
		logic [31:0] arg;
		logic [7:0]  crc;
		logic [7:0]  b;
		idx = IDX_CMD58;
		arg = '0;
		crc = CRC_END;
		case (ph)
			PH_CMD0: begin
				idx = IDX_CMD0;
				crc = CRC_CMD0;
			end
			PH_CMD8: begin
				idx = IDX_CMD8;
				arg = ARG_CMD8;
				crc = CRC_CMD8;
			end
			PH_CMD55: idx = IDX_CMD55;
			PH_ACMD41: begin
				idx = IDX_ACMD41;
				arg = v2 ? ARG_HCS : '0;
			end
			default: idx = IDX_CMD58;
		endcase
		case (k)
			3'd0: b = CMD_START | {2'b00, idx};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: b = crc;
		endcase
		return b;
	endfunction

	function automatic sdi_result_t done_word(input logic [2:0] s, input logic v2,
		input logic [31:0] tw);
		sdi_result_t r;
		r = '0;
		r.done_res = 1'b1;
		r.status = s;
		r.card_v2 = v2;
		r.high_capacity = (s == ST_OK) && (tw[31:30] == 2'b11);
		return r;
	endfunction

	function automatic sdi_result_t xfer_word(input logic [7:0] b, input logic sel,
		input logic pulse);
		sdi_result_t r;
		r = '0;
		r.tx_valid = 1'b1;
		r.tx_byte = b;
		r.select_low = sel;
		r.select_pulse = pulse;
		return r;
	endfunction

	logic       fin;
	logic [2:0] fin_status;
	logic       start_cmd;
	logic [2:0] start_ph;
	logic       in_window;
	logic [2:0] k;
	logic       long_resp;
	logic [9:0] retry_inc;
	logic       v2_next;
	logic       r1_ok;

	always_comb begin
		nx = st;
		res = '0;
		fin = 1'b0;
		fin_status = ST_OK;
		start_cmd = 1'b0;
		start_ph = PH_CMD0;
		in_window = st.poll_count < cfg.response_polls;
		k = 3'(st.byte_count - 5'd6);
		long_resp = (st.phase == PH_CMD8) || (st.phase == PH_CMD58);
		retry_inc = (st.retry_count < RETRY_SAT) ? st.retry_count + 10'd1 : st.retry_count;
		v2_next = st.is_version_two;
		r1_ok = 1'b0;

		if (!kind) begin
			// restart from the dummy clocks
			nx = '0;
			nx.phase = PH_DUMMY;
			nx.byte_count = 5'd1;
			res = xfer_word(FILL_BYTE, 1'b0, 1'b0);
		end else if (st.phase == PH_DONE) begin
			res = done_word(st.final_status, st.is_version_two, st.trailer_word);
		end else if (st.phase == PH_DUMMY) begin
			if (st.byte_count < cfg.dummy_bytes) begin
				nx.byte_count = st.byte_count + 5'd1;
				res = xfer_word(FILL_BYTE, 1'b0, 1'b0);
			end else begin
				start_cmd = 1'b1;
				start_ph = PH_CMD0;
			end
		end else if (st.phase == PH_IDLE) begin
			res = '0;
		end else if (st.byte_count < 5'd6) begin
			res = xfer_word(frame_byte(st.phase, st.byte_count[2:0], st.is_version_two),
				1'b1, 1'b0);
			nx.byte_count = st.byte_count + 5'd1;
		end else if (st.byte_count == 5'd6) begin
			res = xfer_word(FILL_BYTE, 1'b1, 1'b0);
			if (in_window && rx_byte[7]) begin
				nx.poll_count = st.poll_count + 4'd1;
			end else begin
				nx.response_code = rx_byte;
				nx.response_timed_out = !in_window;
				nx.trailer_word = '0;
				nx.byte_count = 5'd7;
			end
		end else begin
			if (long_resp && k <= 3'd4) begin
				nx.trailer_word = {st.trailer_word[23:0], rx_byte};
			end
			if (k < (long_resp ? 3'd5 : 3'd1)) begin
				nx.byte_count = st.byte_count + 5'd1;
				res = xfer_word(FILL_BYTE, 1'b1, 1'b0);
			end else begin
				// response and any trailer bytes are in: judge the response
				unique case (st.phase)
					PH_CMD0: begin
						if (st.response_timed_out || st.response_code != R1_IDLE) begin
							fin = 1'b1;
							fin_status = ST_CMD0_BAD;
						end else begin
							start_cmd = 1'b1;
							start_ph = PH_CMD8;
						end
					end
					PH_CMD8: begin
						if (st.response_timed_out) begin
							fin = 1'b1;
							fin_status = ST_CMD8_BAD;
						end else if (st.response_code[2]) begin
							v2_next = 1'b0;
							r1_ok = 1'b1;
						end else if ((st.response_code & 8'hfe) == 8'h00) begin
							v2_next = 1'b1;
							r1_ok = 1'b1;
						end else begin
							fin = 1'b1;
							fin_status = ST_CMD8_BAD;
						end
						if (r1_ok) begin
							nx.is_version_two = v2_next;
							if (v2_next && st.response_code != R1_IDLE) begin
								fin = 1'b1;
								fin_status = ST_CMD8_BAD;
							end else if (v2_next && st.trailer_word[15:0] != ECHO_PATTERN) begin
								fin = 1'b1;
								fin_status = ST_ECHO_BAD;
							end else begin
								nx.retry_count = '0;
								start_cmd = 1'b1;
								start_ph = PH_CMD55;
							end
						end
					end
					PH_CMD55: begin
						if (st.response_timed_out || st.response_code != R1_IDLE) begin
							fin = 1'b1;
							fin_status = ST_CMD55_BAD;
						end else begin
							start_cmd = 1'b1;
							start_ph = PH_ACMD41;
						end
					end
					PH_ACMD41: begin
						nx.retry_count = retry_inc;
						if (!st.response_timed_out && st.response_code == R1_READY) begin
							start_cmd = 1'b1;
							start_ph = PH_CMD58;
						end else if (!st.response_timed_out && st.response_code == R1_IDLE) begin
							if (retry_inc < cfg.acmd41_retries) begin
								start_cmd = 1'b1;
								start_ph = PH_CMD55;
							end else begin
								fin = 1'b1;
								fin_status = ST_RETRY_OUT;
							end
						end else begin
							fin = 1'b1;
							fin_status = ST_ACMD41_BAD;
						end
					end
					default: begin
						fin = 1'b1;
						fin_status = ST_OK;
					end
				endcase
			end
		end

		if (start_cmd) begin
			nx.phase = start_ph;
			nx.byte_count = 5'd1;
			nx.poll_count = '0;
			res = xfer_word(frame_byte(start_ph, 3'd0, nx.is_version_two), 1'b1, 1'b1);
		end
		if (fin) begin
			nx.phase = PH_DONE;
			nx.final_status = fin_status;
			res = done_word(fin_status, nx.is_version_two, nx.trailer_word);
		end
	end

endmodule

// ===== src/sd_spi_init_sequencer_core.sv =====
// Top level of the SD card SPI-mode init sequencer.
// Depends on sdi_pkg, the channel interfaces in sdi_if.sv and sdi_step.
//
//  channel | dir | payload                                   | accepted when
//  item    | in  | kind, rx_byte                             | valid & ready
//  result  | out | tx_valid, tx_byte, select_low/pulse,      | valid & ready
//          |     | done_res, status, card_v2, high_capacity  |
//  cfg     | in  | addr (register index), data               | valid & ready (always ready)
//
// One word per cycle sustained while the result is taken: an accepted word is held in
// the input register, the step logic turns it into the next state and a result in the
// same cycle, and the result register holds it until taken. Result valid rises when the
// word moves from the input register into the result register. Input ready drops only
// while both registers are full and the result is stalled. Reset clears the
// sequencer state to idle and loads the default config.
module sd_spi_init_sequencer_core (
	input logic         clk,
	input logic         arst_n,
	sdi_item_if.sink    item,
	sdi_result_if.source result,
	sdi_cfg_if.sink     cfg
);
	import sdi_pkg::*;

	sdi_cfg_t    cfg_q;
	sdi_state_t  state_q;
	sdi_state_t  state_nx;
	sdi_result_t res_nx;
	sdi_result_t res_q;
	logic        out_vld_q;
	logic        vld_s1;
	logic        kind_s1;
	logic [7:0]  rx_s1;
	logic        adv;
	logic        item_acc;

	assign adv = vld_s1 && (!out_vld_q || result.ready);
	assign item.ready = !vld_s1 || adv;
	assign item_acc = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	sdi_step u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.kind    (kind_s1),
		.rx_byte (rx_s1),
		.nx      (state_nx),
		.res     (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dummy_bytes <= DUMMY_RST;
			cfg_q.response_polls <= POLLS_RST;
			cfg_q.acmd41_retries <= RETRIES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_DUMMY_BYTES: cfg_q.dummy_bytes <= cfg.data[4:0];
				REG_RESP_POLLS: cfg_q.response_polls <= cfg.data[3:0];
				REG_ACMD41_RETRIES: cfg_q.acmd41_retries <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			state_q <= '0;
		end else begin
			vld_s1 <= item_acc || (vld_s1 && !adv);
			out_vld_q <= adv || (out_vld_q && !result.ready);
			if (adv) begin
				state_q <= state_nx;
			end
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (item_acc) begin
			kind_s1 <= item.kind;
			rx_s1 <= item.rx_byte;
		end
		if (adv) begin
			res_q <= res_nx;
		end
	end

	assign result.valid = out_vld_q;
	assign result.tx_valid = res_q.tx_valid;
	assign result.tx_byte = res_q.tx_byte;
	assign result.select_low = res_q.select_low;
	assign result.select_pulse = res_q.select_pulse;
	assign result.done_res = res_q.done_res;
	assign result.status = res_q.status;
	assign result.card_v2 = res_q.card_v2;
	assign result.high_capacity = res_q.high_capacity;

endmodule

// ===== src/sdi_checker.sv =====
// Port-level checks for the SD card SPI init sequencer, bound to the top level.
// Depends on assert_macros.svh and sdi_pkg.
`include "assert_macros.svh"

module sdi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       tx_valid,
	input logic [7:0] tx_byte,
	input logic       select_low,
	input logic       select_pulse,
	input logic       done_res,
	input logic [2:0] status,
	input logic       card_v2,
	input logic       high_capacity
);
	import sdi_pkg::*;

	// a stalled word holds
	`SDI_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(tx_byte))
	// a done word requests no transfer
	`SDI_ASSERT_NEVER(a_done_no_xfer, out_valid && done_res && (tx_valid || select_low))
	// transfer words carry no status
	`SDI_ASSERT_NEVER(a_xfer_no_status, out_valid && !done_res && (status != ST_OK || card_v2 || high_capacity))
	// a chip select pulse only opens a selected transfer
	`SDI_ASSERT_NEVER(a_pulse_selected, out_valid && select_pulse && !(tx_valid && select_low))
	// capacity class is only reported on success
	`SDI_ASSERT_NEVER(a_hc_ok_only, out_valid && high_capacity && status != ST_OK)

endmodule

bind sd_spi_init_sequencer_core sdi_checker u_sdi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.tx_valid      (result.tx_valid),
	.tx_byte       (result.tx_byte),
	.select_low    (result.select_low),
	.select_pulse  (result.select_pulse),
	.done_res      (result.done_res),
	.status        (result.status),
	.card_v2       (result.card_v2),
	.high_capacity (result.high_capacity)
);
